[hw/rtl/merge_sort_engine_defines.svh]
// Assertion macros used by the file that checks the merge sort engine.
// Each macro samples on the rising edge of clock and is off while reset is high.
`ifndef MERGE_SORT_ENGINE_DEFINES_SVH
`define MERGE_SORT_ENGINE_DEFINES_SVH

`define MSE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define MSE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/mse_pkg.sv]
`default_nettype none
package mse_pkg;

   localparam int MAX_ELEMENTS = 64;
   localparam int VALUE_WIDTH  = 32;
   localparam int IDX_W        = $clog2(MAX_ELEMENTS);
   localparam int CNT_W        = $clog2(MAX_ELEMENTS) + 1;
   localparam int SUM_W        = CNT_W + 2;

   typedef logic [IDX_W-1:0]              idx_type;
   typedef logic [CNT_W-1:0]              cnt_type;
   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   typedef struct packed {
      value_type value;
      logic      last_item;
   } req_type;

   typedef struct packed {
      value_type sorted_value;
      logic      last_result;
      logic      overflow;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_LOAD  = 5'b00001,
      ST_SETUP = 5'b00010,
      ST_MERGE = 5'b00100,
      ST_PRIME = 5'b01000,
      ST_EMIT  = 5'b10000
   } seq_state_type;

   typedef struct packed {
      logic      wr_a;
      logic      wr_b;
      idx_type   wr_addr;
      value_type wr_data;
      idx_type   rd_addr0;
      idx_type   rd_addr1;
   } mem_ctl_type;

endpackage
`default_nettype wire

[hw/rtl/mse_ram.sv]
`default_nettype none
module mse_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr0,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr1,
   output logic      [WIDTH-1:0]         rd_data0,
   output logic      [WIDTH-1:0]         rd_data1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd0_ff;
   logic [WIDTH-1:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd0_ff <= mem_ff[rd_addr0];
      rd1_ff <= mem_ff[rd_addr1];
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;

endmodule
`default_nettype wire

[hw/rtl/mse_cmp.sv]
`default_nettype none
module mse_cmp (
   input  wire mse_pkg::value_type head_a,
   input  wire mse_pkg::value_type head_b,
   input  wire logic               a_live,
   input  wire logic               b_live,
   output logic                    take_a
);

   // Ties go to the left run, which keeps the sort stable.
   assign take_a = a_live && (!b_live || (head_a <= head_b));

endmodule
`default_nettype wire

[hw/rtl/mse_seq.sv]
`default_nettype none
module mse_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire mse_pkg::req_type     req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output mse_pkg::rsp_type          rsp_data,
   output mse_pkg::mem_ctl_type      mem,
   output logic                      src_sel,
   input  wire mse_pkg::value_type   rd_head0,
   input  wire mse_pkg::value_type   rd_head1,
   output logic                      a_live,
   output logic                      b_live,
   input  wire logic                 take_a
);

   mse_pkg::seq_state_type state_ff, state_in;
   mse_pkg::cnt_type count_ff, count_in;
   logic             ovf_ff, ovf_in;
   mse_pkg::cnt_type width_ff, width_in;
   logic             src_sel_ff, src_sel_in;
   mse_pkg::cnt_type a_idx_ff, a_idx_in;
   mse_pkg::cnt_type a_end_ff, a_end_in;
   mse_pkg::cnt_type b_idx_ff, b_idx_in;
   mse_pkg::cnt_type b_end_ff, b_end_in;
   mse_pkg::cnt_type k_ff, k_in;
   mse_pkg::cnt_type e_idx_ff, e_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   mse_pkg::rsp_type rsp_data_ff, rsp_data_in;

   mse_pkg::cnt_type blk_base;
   logic [mse_pkg::SUM_W-1:0] mid_sum;
   logic [mse_pkg::SUM_W-1:0] hi_sum;
   mse_pkg::cnt_type blk_mid;
   mse_pkg::cnt_type blk_hi;
   mse_pkg::cnt_type k_next;
   mse_pkg::cnt_type e_next;
   logic             blk_done;
   logic             pass_done;
   logic             out_free;
   logic             emit_last;
   mse_pkg::value_type out_pick;

   assign a_live    = a_idx_ff < a_end_ff;
   assign b_live    = b_idx_ff < b_end_ff;
   assign out_pick  = take_a ? rd_head0 : rd_head1;
   assign k_next    = k_ff + 1'b1;
   assign e_next    = e_idx_ff + 1'b1;
   assign blk_done  = k_next == b_end_ff;
   assign pass_done = blk_done && (b_end_ff == count_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_last = e_next == count_ff;

   // Bounds of the next pair of runs, clipped to the number of stored words.
   assign blk_base = (state_ff == mse_pkg::ST_SETUP) ? '0 : b_end_ff;
   assign mid_sum  = mse_pkg::SUM_W'(blk_base) + mse_pkg::SUM_W'(width_ff);
   assign hi_sum   = mid_sum + mse_pkg::SUM_W'(width_ff);
   assign blk_mid  = (mid_sum > mse_pkg::SUM_W'(count_ff)) ?
                     count_ff : mse_pkg::CNT_W'(mid_sum);
   assign blk_hi   = (hi_sum > mse_pkg::SUM_W'(count_ff)) ?
                     count_ff : mse_pkg::CNT_W'(hi_sum);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      width_in     = width_ff;
      src_sel_in   = src_sel_ff;
      a_idx_in     = a_idx_ff;
      a_end_in     = a_end_ff;
      b_idx_in     = b_idx_ff;
      b_end_in     = b_end_ff;
      k_in         = k_ff;
      e_idx_in     = e_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem.wr_a     = 1'b0;
      mem.wr_b     = 1'b0;
      mem.wr_addr  = k_ff[mse_pkg::IDX_W-1:0];
      mem.wr_data  = out_pick;

      case (state_ff)
         mse_pkg::ST_LOAD: begin
            if (req_valid) begin
               if (count_ff < mse_pkg::CNT_W'(mse_pkg::MAX_ELEMENTS)) begin
                  mem.wr_a    = 1'b1;
                  mem.wr_addr = count_ff[mse_pkg::IDX_W-1:0];
                  mem.wr_data = req_data.value;
                  count_in    = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last_item) begin
                  state_in   = mse_pkg::ST_SETUP;
                  width_in   = mse_pkg::CNT_W'(1);
                  src_sel_in = 1'b0;
               end
            end
         end
         mse_pkg::ST_SETUP: begin
            if (width_ff >= count_ff) begin
               state_in = mse_pkg::ST_PRIME;
            end else begin
               a_idx_in = '0;
               a_end_in = blk_mid;
               b_idx_in = blk_mid;
               b_end_in = blk_hi;
               k_in     = '0;
               state_in = mse_pkg::ST_MERGE;
            end
         end
         mse_pkg::ST_MERGE: begin
            mem.wr_a = src_sel_ff;
            mem.wr_b = !src_sel_ff;
            k_in     = k_next;
            if (take_a) begin
               a_idx_in = a_idx_ff + 1'b1;
            end else begin
               b_idx_in = b_idx_ff + 1'b1;
            end
            if (pass_done) begin
               state_in   = mse_pkg::ST_SETUP;
               src_sel_in = !src_sel_ff;
               width_in   = {width_ff[mse_pkg::CNT_W-2:0], 1'b0};
            end else if (blk_done) begin
               a_idx_in = b_end_ff;
               a_end_in = blk_mid;
               b_idx_in = blk_mid;
               b_end_in = blk_hi;
            end
         end
         mse_pkg::ST_PRIME: begin
            e_idx_in = '0;
            state_in = mse_pkg::ST_EMIT;
         end
         mse_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.sorted_value = rd_head0;
               rsp_data_in.last_result  = emit_last;
               rsp_data_in.overflow     = ovf_ff;
               if (emit_last) begin
                  state_in = mse_pkg::ST_LOAD;
                  count_in = '0;
                  ovf_in   = 1'b0;
               end else begin
                  e_idx_in = e_next;
               end
            end
         end
         default: begin
            state_in = mse_pkg::ST_LOAD;
         end
      endcase

      // Reads are issued from next-cycle indices so the heads line up with the indices.
      mem.rd_addr0 = (state_in == mse_pkg::ST_EMIT) ? e_idx_in[mse_pkg::IDX_W-1:0] :
                     a_idx_in[mse_pkg::IDX_W-1:0];
      mem.rd_addr1 = b_idx_in[mse_pkg::IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mse_pkg::ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         width_ff     <= '0;
         src_sel_ff   <= 1'b0;
         a_idx_ff     <= '0;
         a_end_ff     <= '0;
         b_idx_ff     <= '0;
         b_end_ff     <= '0;
         k_ff         <= '0;
         e_idx_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         width_ff     <= width_in;
         src_sel_ff   <= src_sel_in;
         a_idx_ff     <= a_idx_in;
         a_end_ff     <= a_end_in;
         b_idx_ff     <= b_idx_in;
         b_end_ff     <= b_end_in;
         k_ff         <= k_in;
         e_idx_ff     <= e_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = state_ff == mse_pkg::ST_LOAD;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign src_sel   = src_sel_ff;

endmodule
`default_nettype wire

[hw/rtl/merge_sort_engine.sv]
`default_nettype none
// Sorts a set of up to 64 signed 32-bit words into ascending order with a stable
// bottom-up merge sort. Words are loaded at one per cycle while req_ready is high;
// the word flagged last_item ends the set, and words beyond the 64th are dropped
// and flag overflow on every result of that set. The sort then ping-pongs between
// two dual-read memories, with one comparator merging one word per cycle within
// a pass, and ceil(log2(n)) passes are run for n stored words. After a priming
// state the results leave at one word per cycle when rsp_ready allows. No new
// word is accepted from the last word of a set until its final result has been
// handed to the output register.
module merge_sort_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire mse_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output mse_pkg::rsp_type      rsp_data
);

   mse_pkg::mem_ctl_type mem;
   logic                 src_sel;
   logic                 a_live;
   logic                 b_live;
   logic                 take_a;
   logic [mse_pkg::VALUE_WIDTH-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
   mse_pkg::value_type   rd_head0;
   mse_pkg::value_type   rd_head1;

   mse_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .mem       (mem),
      .src_sel   (src_sel),
      .rd_head0  (rd_head0),
      .rd_head1  (rd_head1),
      .a_live    (a_live),
      .b_live    (b_live),
      .take_a    (take_a)
   );

   mse_ram #(
      .DEPTH (mse_pkg::MAX_ELEMENTS),
      .WIDTH (mse_pkg::VALUE_WIDTH)
   ) u_ram_a (
      .clock    (clock),
      .wr_en    (mem.wr_a),
      .wr_addr  (mem.wr_addr),
      .wr_data  (mem.wr_data),
      .rd_addr0 (mem.rd_addr0),
      .rd_addr1 (mem.rd_addr1),
      .rd_data0 (a_rd0),
      .rd_data1 (a_rd1)
   );

   mse_ram #(
      .DEPTH (mse_pkg::MAX_ELEMENTS),
      .WIDTH (mse_pkg::VALUE_WIDTH)
   ) u_ram_b (
      .clock    (clock),
      .wr_en    (mem.wr_b),
      .wr_addr  (mem.wr_addr),
      .wr_data  (mem.wr_data),
      .rd_addr0 (mem.rd_addr0),
      .rd_addr1 (mem.rd_addr1),
      .rd_data0 (b_rd0),
      .rd_data1 (b_rd1)
   );

   assign rd_head0 = src_sel ? b_rd0 : a_rd0;
   assign rd_head1 = src_sel ? b_rd1 : a_rd1;

   mse_cmp u_cmp (
      .head_a (rd_head0),
      .head_b (rd_head1),
      .a_live (a_live),
      .b_live (b_live),
      .take_a (take_a)
   );

endmodule
`default_nettype wire

[hw/rtl/mse_checker.sv]
`default_nettype none
`include "merge_sort_engine_defines.svh"
module mse_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire mse_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire mse_pkg::rsp_type rsp_data
);

   logic               rsp_fire;
   logic               in_set_ff, in_set_in;
   mse_pkg::value_type prev_val_ff, prev_val_in;
   logic               prev_ovf_ff, prev_ovf_in;

   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      in_set_in   = in_set_ff;
      prev_val_in = prev_val_ff;
      prev_ovf_in = prev_ovf_ff;
      if (rsp_fire) begin
         in_set_in   = !rsp_data.last_result;
         prev_val_in = rsp_data.sorted_value;
         prev_ovf_in = rsp_data.overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_set_ff <= 1'b0;
      end else begin
         in_set_ff <= in_set_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_val_ff <= prev_val_in;
      prev_ovf_ff <= prev_ovf_in;
   end

   `MSE_ASSERT_SAME(a_sorted_order, rsp_fire && in_set_ff, rsp_data.sorted_value >= prev_val_ff, "result word out of ascending order")
   `MSE_ASSERT_SAME(a_overflow_steady, rsp_fire && in_set_ff, rsp_data.overflow == prev_ovf_ff, "overflow flag changed within a set")
   `MSE_ASSERT_NEXT(a_busy_after_last, req_valid && req_ready && req_data.last_item, !req_ready, "input still ready after the last word of a set")
   `MSE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result word was not held")

endmodule

bind merge_sort_engine mse_checker u_checker (.*);
`default_nettype wire
